/* src/hlsml_pkg.sv */
// Shared types and constants of the hierarchical land/sea mask lookup.
`default_nettype none

package hlsml_pkg;

   // command codes
   localparam logic [1:0] CMD_QUERY  = 2'd0;
   localparam logic [1:0] CMD_GRID   = 2'd1;
   localparam logic [1:0] CMD_TENTH  = 2'd2;
   localparam logic [1:0] CMD_BITMAP = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   // deciding level codes, also the resolution register codes
   localparam logic [1:0] LEVEL_NONE      = 2'd0;
   localparam logic [1:0] LEVEL_DEGREE    = 2'd1;
   localparam logic [1:0] LEVEL_TENTH     = 2'd2;
   localparam logic [1:0] LEVEL_HUNDREDTH = 2'd3;

   localparam logic [1:0] RESOLUTION_RESET = LEVEL_HUNDREDTH;

   localparam int ENTRY_LAND = -2;
   localparam int ENTRY_SEA  = -1;

   localparam int GRID_ROWS        = 180;
   localparam int GRID_COLUMNS     = 360;
   localparam int GRID_DEPTH       = GRID_ROWS * GRID_COLUMNS;
   localparam int GRID_ADDR_W      = $clog2(GRID_DEPTH);
   localparam int GRID_DATA_W      = 16;
   localparam int TENTH_DATA_W     = 21;
   localparam int BITMAP_DATA_W    = 8;
   localparam int CELLS_PER_BLOCK  = 100;
   localparam int BYTES_PER_BITMAP = 14;

   // coordinates in 16 fraction bits
   localparam logic signed [24:0] LAT_OFFSET = 25'sd5898240;   // 90 degrees
   localparam logic signed [24:0] LON_OFFSET = 25'sd11796480;  // 180 degrees
   localparam int ROUND_HALF  = 32768;
   localparam int LAT100_MAX  = GRID_ROWS * 100 - 1;
   localparam int LON100_WRAP = GRID_COLUMNS * 100;

   // reciprocal multiplies, exact below 36000 and below 100
   localparam int RECIP_100       = 5243;
   localparam int RECIP_100_SHIFT = 19;
   localparam int RECIP_10        = 205;
   localparam int RECIP_10_SHIFT  = 11;

   localparam int FRONT_STAGES = 4;
   localparam int INFLIGHT_W   = $clog2(FRONT_STAGES + 1);
   localparam int QUEUE_DEPTH  = 4;   // power of two, pointers wrap naturally
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int OCCUPANCY_W  = QUEUE_CNT_W + 1;

   typedef struct packed {
      logic [1:0]             command;
      logic [19:0]            table_address;
      logic [20:0]            table_data;
      logic                   range_error;
      logic [GRID_ADDR_W-1:0] grid_index;
      logic [6:0]             tenth_offset;
      logic [6:0]             bit_index;
   } item_type;

   typedef struct packed {
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

/* src/hlsml_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hlsml_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/hlsml_front.sv */
// Front end: range check, rounding to hundredths and digit split of each item.
`default_nettype none

module hlsml_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            command,
   input  wire logic signed [24:0]    latitude,
   input  wire logic signed [24:0]    longitude,
   input  wire logic [19:0]           table_address,
   input  wire logic signed [20:0]    table_data,
   output logic                       push,
   output hlsml_pkg::item_type        item,
   output logic [hlsml_pkg::INFLIGHT_W-1:0] inflight
);

   // stage valid bits
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;

   // fields carried down the stages
   hlsml_pkg::item_type f1_item_ff, f2_item_ff, f3_item_ff, f4_item_ff;
   hlsml_pkg::item_type f1_item_in, f2_item_in;

   logic signed [24:0] f1_lat_ff, f1_lon_ff;

   logic        f2_range_error_in;
   logic [24:0] f2_lat_u_in, f2_lon_u_in, f2_lat_u_ff, f2_lon_u_ff;
   logic signed [25:0] lat_sum, lon_sum;

   logic [31:0] lat_round, lon_round;
   logic [15:0] lat_h, lon_h;
   logic [14:0] f3_lat100_in, f3_lat100_ff;
   logic [15:0] f3_lon100_in, f3_lon100_ff;

   logic [31:0] lat_q, lon_q, lat_rest, lon_rest;
   logic [7:0]  f4_row_in, f4_row_ff;
   logic [8:0]  f4_col_in, f4_col_ff;
   logic [6:0]  f4_lat_rem_in, f4_lat_rem_ff, f4_lon_rem_in, f4_lon_rem_ff;

   logic [14:0] lat_t, lon_t;
   logic [3:0]  lat_tens, lon_tens, lat_ones, lon_ones;

   // stage 0 -> 1: fields of the accepted item
   always_comb begin
      f1_item_in               = '0;
      f1_item_in.command       = command;
      f1_item_in.table_address = table_address;
      f1_item_in.table_data    = table_data;
   end

   // stage 1 -> 2: range check and shift to non-negative
   always_comb begin
      lat_sum = 26'(f1_lat_ff) + 26'(hlsml_pkg::LAT_OFFSET);
      lon_sum = 26'(f1_lon_ff) + 26'(hlsml_pkg::LON_OFFSET);
      f2_lat_u_in = lat_sum[24:0];
      f2_lon_u_in = lon_sum[24:0];
      f2_range_error_in = (f1_lat_ff < -hlsml_pkg::LAT_OFFSET) ||
                          (f1_lat_ff > hlsml_pkg::LAT_OFFSET) ||
                          (f1_lon_ff < -hlsml_pkg::LON_OFFSET) ||
                          (f1_lon_ff > hlsml_pkg::LON_OFFSET);
      f2_item_in             = f1_item_ff;
      f2_item_in.range_error = f2_range_error_in;
   end

   // stage 2 -> 3: round half up to hundredths, clamp pole, wrap date line
   always_comb begin
      lat_round = 32'(f2_lat_u_ff) * 32'd100 + 32'(hlsml_pkg::ROUND_HALF);
      lon_round = 32'(f2_lon_u_ff) * 32'd100 + 32'(hlsml_pkg::ROUND_HALF);
      lat_h = lat_round[31:16];
      lon_h = lon_round[31:16];
      if (lat_h > 16'(hlsml_pkg::LAT100_MAX)) begin
         f3_lat100_in = 15'(hlsml_pkg::LAT100_MAX);
      end else begin
         f3_lat100_in = lat_h[14:0];
      end
      if (lon_h >= 16'(hlsml_pkg::LON100_WRAP)) begin
         f3_lon100_in = lon_h - 16'(hlsml_pkg::LON100_WRAP);
      end else begin
         f3_lon100_in = lon_h;
      end
   end

   // stage 3 -> 4: whole degrees and the remaining hundredths
   always_comb begin
      lat_q = (32'(f3_lat100_ff) * 32'(hlsml_pkg::RECIP_100)) >> hlsml_pkg::RECIP_100_SHIFT;
      lon_q = (32'(f3_lon100_ff) * 32'(hlsml_pkg::RECIP_100)) >> hlsml_pkg::RECIP_100_SHIFT;
      f4_row_in = lat_q[7:0];
      f4_col_in = lon_q[8:0];
      lat_rest = 32'(f3_lat100_ff) - 32'(f4_row_in) * 32'd100;
      lon_rest = 32'(f3_lon100_ff) - 32'(f4_col_in) * 32'd100;
      f4_lat_rem_in = lat_rest[6:0];
      f4_lon_rem_in = lon_rest[6:0];
   end

   // stage 4: tenth and hundredth digits, table offsets
   always_comb begin
      lat_t = 15'(f4_lat_rem_ff) * 15'(hlsml_pkg::RECIP_10);
      lon_t = 15'(f4_lon_rem_ff) * 15'(hlsml_pkg::RECIP_10);
      lat_tens = 4'(lat_t >> hlsml_pkg::RECIP_10_SHIFT);
      lon_tens = 4'(lon_t >> hlsml_pkg::RECIP_10_SHIFT);
      lat_ones = 4'(f4_lat_rem_ff - 7'(lat_tens) * 7'd10);
      lon_ones = 4'(f4_lon_rem_ff - 7'(lon_tens) * 7'd10);
      item = f4_item_ff;
      item.tenth_offset = 7'(lat_tens) * 7'd10 + 7'(lon_tens);
      item.bit_index    = 7'(lat_ones) * 7'd10 + 7'(lon_ones);
      item.grid_index   = hlsml_pkg::GRID_ADDR_W'(f4_row_ff) *
                          hlsml_pkg::GRID_ADDR_W'(hlsml_pkg::GRID_COLUMNS) +
                          hlsml_pkg::GRID_ADDR_W'(f4_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_item_ff <= f1_item_in;
      f1_lat_ff  <= latitude;
      f1_lon_ff  <= longitude;

      f2_item_ff  <= f2_item_in;
      f2_lat_u_ff <= f2_lat_u_in;
      f2_lon_u_ff <= f2_lon_u_in;

      f3_item_ff   <= f2_item_ff;
      f3_lat100_ff <= f3_lat100_in;
      f3_lon100_ff <= f3_lon100_in;

      f4_item_ff    <= f3_item_ff;
      f4_row_ff     <= f4_row_in;
      f4_col_ff     <= f4_col_in;
      f4_lat_rem_ff <= f4_lat_rem_in;
      f4_lon_rem_ff <= f4_lon_rem_in;
   end

   assign push     = f4_valid_ff;
   assign inflight = hlsml_pkg::INFLIGHT_W'(f1_valid_ff) + hlsml_pkg::INFLIGHT_W'(f2_valid_ff) +
                     hlsml_pkg::INFLIGHT_W'(f3_valid_ff) + hlsml_pkg::INFLIGHT_W'(f4_valid_ff);

endmodule

`default_nettype wire

/* src/hlsml_queue.sv */
// Short FIFO of classified items between front end and table walker.
`default_nettype none

module hlsml_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire hlsml_pkg::item_type     push_item,
   input  wire logic                    pop,
   output hlsml_pkg::item_type          head,
   output hlsml_pkg::queue_status_type  status
);

   hlsml_pkg::item_type entry_ff [hlsml_pkg::QUEUE_DEPTH];

   logic [hlsml_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [hlsml_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + hlsml_pkg::QUEUE_CNT_W'(push) - hlsml_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < hlsml_pkg::QUEUE_CNT_W'(hlsml_pkg::QUEUE_DEPTH)) || pop)
      else $error("item pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("item popped from an empty queue");

endmodule

`default_nettype wire

/* src/hlsml_back.sv */
// Table walker: carries out writes and walks grid, tenth blocks and bitmaps.
`default_nettype none

module hlsml_back #(
   parameter int TENTH_BLOCK_COUNT  = 4096,
   parameter int BITMAP_BLOCK_COUNT = 65536
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hlsml_pkg::item_type       q_head,
   input  wire hlsml_pkg::queue_status_type q_status,
   output logic                           q_pop,
   input  wire logic                      cfg_write,
   input  wire logic [1:0]                cfg_data,
   output logic                           rsp_strobe,
   output logic                           rsp_land,
   output logic [1:0]                     rsp_status,
   output logic [1:0]                     rsp_decided_level
);

   localparam int TENTH_DEPTH  = TENTH_BLOCK_COUNT * hlsml_pkg::CELLS_PER_BLOCK;
   localparam int TENTH_ADDR_W = $clog2(TENTH_DEPTH);
   localparam int TBLK_W       = $clog2(TENTH_BLOCK_COUNT + 1);
   localparam int BITMAP_DEPTH  = BITMAP_BLOCK_COUNT * hlsml_pkg::BYTES_PER_BITMAP;
   localparam int BITMAP_ADDR_W = $clog2(BITMAP_DEPTH);
   localparam int BBLK_W        = $clog2(BITMAP_BLOCK_COUNT + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_GRID     = 3'd2;
   localparam logic [2:0] ST_TENTH    = 3'd3;
   localparam logic [2:0] ST_BITMAP   = 3'd4;

   logic [2:0] state_ff, state_in;
   hlsml_pkg::item_type cur_ff, cur_in;
   logic [1:0] resolution_ff;

   logic       rsp_strobe_ff, rsp_strobe_in;
   logic       rsp_land_ff, rsp_land_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [1:0] rsp_level_ff, rsp_level_in;

   logic grid_we, grid_re, tenth_we, tenth_re, bitmap_we, bitmap_re;
   logic [hlsml_pkg::GRID_DATA_W-1:0]   grid_rd;
   logic [hlsml_pkg::TENTH_DATA_W-1:0]  tenth_rd;
   logic [hlsml_pkg::BITMAP_DATA_W-1:0] bitmap_rd;
   logic [TENTH_ADDR_W-1:0]  tenth_rd_addr;
   logic [BITMAP_ADDR_W-1:0] bitmap_rd_addr;

   logic signed [15:0] dv;
   logic signed [20:0] tv;
   logic signed [15:0] dv_m1;
   logic signed [20:0] tv_m1;

   always_comb begin
      dv    = $signed(grid_rd);
      tv    = $signed(tenth_rd);
      dv_m1 = dv - 16'sd1;
      tv_m1 = tv - 21'sd1;
      tenth_rd_addr = TENTH_ADDR_W'(TBLK_W'(dv_m1)) *
                      TENTH_ADDR_W'(hlsml_pkg::CELLS_PER_BLOCK) +
                      TENTH_ADDR_W'(cur_ff.tenth_offset);
      bitmap_rd_addr = BITMAP_ADDR_W'(BBLK_W'(tv_m1)) *
                       BITMAP_ADDR_W'(hlsml_pkg::BYTES_PER_BITMAP) +
                       BITMAP_ADDR_W'(cur_ff.bit_index[6:3]);
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      q_pop         = 1'b0;
      grid_we       = 1'b0;
      grid_re       = 1'b0;
      tenth_we      = 1'b0;
      tenth_re      = 1'b0;
      bitmap_we     = 1'b0;
      bitmap_re     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_land_in   = 1'b0;
      rsp_status_in = hlsml_pkg::STATUS_OK;
      rsp_level_in  = hlsml_pkg::LEVEL_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (cur_ff.command)
               hlsml_pkg::CMD_GRID: begin
                  grid_we       = 32'(cur_ff.table_address) < hlsml_pkg::GRID_DEPTH;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               hlsml_pkg::CMD_TENTH: begin
                  tenth_we      = 32'(cur_ff.table_address) < TENTH_DEPTH;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               hlsml_pkg::CMD_BITMAP: begin
                  bitmap_we     = 32'(cur_ff.table_address) < BITMAP_DEPTH;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
               hlsml_pkg::CMD_QUERY: begin
                  if (cur_ff.range_error) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = hlsml_pkg::STATUS_RANGE;
                     state_in      = ST_IDLE;
                  end else begin
                     grid_re  = 1'b1;
                     state_in = ST_GRID;
                  end
               end
            endcase
         end
         ST_GRID: begin
            state_in = ST_IDLE;
            priority if (int'(dv) == hlsml_pkg::ENTRY_LAND) begin
               rsp_strobe_in = 1'b1;
               rsp_land_in   = 1'b1;
               rsp_level_in  = hlsml_pkg::LEVEL_DEGREE;
            end else if (int'(dv) == hlsml_pkg::ENTRY_SEA) begin
               rsp_strobe_in = 1'b1;
               rsp_level_in  = hlsml_pkg::LEVEL_DEGREE;
            end else if (resolution_ff == hlsml_pkg::LEVEL_DEGREE) begin
               // mixed cell at coarse resolution counts as land
               rsp_strobe_in = 1'b1;
               rsp_land_in   = 1'b1;
               rsp_level_in  = hlsml_pkg::LEVEL_DEGREE;
            end else if (int'(dv) < 1 || int'(dv) > TENTH_BLOCK_COUNT) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = hlsml_pkg::STATUS_BAD;
            end else begin
               tenth_re = 1'b1;
               state_in = ST_TENTH;
            end
         end
         ST_TENTH: begin
            state_in = ST_IDLE;
            priority if (int'(tv) == hlsml_pkg::ENTRY_LAND) begin
               rsp_strobe_in = 1'b1;
               rsp_land_in   = 1'b1;
               rsp_level_in  = hlsml_pkg::LEVEL_TENTH;
            end else if (int'(tv) == hlsml_pkg::ENTRY_SEA) begin
               rsp_strobe_in = 1'b1;
               rsp_level_in  = hlsml_pkg::LEVEL_TENTH;
            end else if (resolution_ff == hlsml_pkg::LEVEL_TENTH) begin
               rsp_strobe_in = 1'b1;
               rsp_land_in   = 1'b1;
               rsp_level_in  = hlsml_pkg::LEVEL_TENTH;
            end else if (int'(tv) < 1 || int'(tv) > BITMAP_BLOCK_COUNT) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = hlsml_pkg::STATUS_BAD;
            end else begin
               bitmap_re = 1'b1;
               state_in  = ST_BITMAP;
            end
         end
         ST_BITMAP: begin
            rsp_strobe_in = 1'b1;
            rsp_land_in   = bitmap_rd[cur_ff.bit_index[2:0]];
            rsp_level_in  = hlsml_pkg::LEVEL_HUNDREDTH;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         resolution_ff <= hlsml_pkg::RESOLUTION_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (cfg_write) begin
            resolution_ff <= cfg_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_land_ff   <= rsp_land_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
   end

   hlsml_ram #(
      .WIDTH (hlsml_pkg::GRID_DATA_W),
      .DEPTH (hlsml_pkg::GRID_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (hlsml_pkg::GRID_ADDR_W'(cur_ff.table_address)),
      .wr_data (cur_ff.table_data[hlsml_pkg::GRID_DATA_W-1:0]),
      .rd_en   (grid_re),
      .rd_addr (cur_ff.grid_index),
      .rd_data (grid_rd)
   );

   hlsml_ram #(
      .WIDTH (hlsml_pkg::TENTH_DATA_W),
      .DEPTH (TENTH_DEPTH)
   ) u_tenth_ram (
      .clock   (clock),
      .wr_en   (tenth_we),
      .wr_addr (TENTH_ADDR_W'(cur_ff.table_address)),
      .wr_data (cur_ff.table_data),
      .rd_en   (tenth_re),
      .rd_addr (tenth_rd_addr),
      .rd_data (tenth_rd)
   );

   hlsml_ram #(
      .WIDTH (hlsml_pkg::BITMAP_DATA_W),
      .DEPTH (BITMAP_DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bitmap_we),
      .wr_addr (BITMAP_ADDR_W'(cur_ff.table_address)),
      .wr_data (cur_ff.table_data[hlsml_pkg::BITMAP_DATA_W-1:0]),
      .rd_en   (bitmap_re),
      .rd_addr (bitmap_rd_addr),
      .rd_data (bitmap_rd)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_land          = rsp_land_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_decided_level = rsp_level_ff;

   a_grid_after_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRID) |-> ($past(state_ff) == ST_DISPATCH))
      else $error("grid lookup without dispatched query");

   a_result_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result issued while item still in progress");

   a_sea_has_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_land_ff) |->
         (rsp_status_ff == hlsml_pkg::STATUS_OK && rsp_level_ff != hlsml_pkg::LEVEL_NONE))
      else $error("land reported without a deciding level");

endmodule

`default_nettype wire

/* src/hierarchical_land_sea_mask_lookup_top.sv */
// Top level of the hierarchical land/sea mask lookup.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+-----------------------------
//  request | req_command/latitude/longitude/table_*   | taken when start && !busy
//  result  | rsp_land, rsp_status, rsp_decided_level  | one cycle with rsp_strobe
//  config  | csr_data (resolution)                    | csr_valid && csr_ready
//
// The front end takes a new item before the last is done; the table walker, which sets
// the sustained rate, takes one item at a time: a write in dispatch, a query in dispatch
// then grid, tenth and bitmap reads as needed. Up to 4 items may sit between the halves.
// Reset sets resolution to hundredths; the tables are not cleared and hold nothing
// until written. The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module hierarchical_land_sea_mask_lookup_top #(
   parameter int TENTH_BLOCK_COUNT  = 4096,
   parameter int BITMAP_BLOCK_COUNT = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_command,
   input  wire logic signed [24:0] req_latitude,
   input  wire logic signed [24:0] req_longitude,
   input  wire logic [19:0]        req_table_address,
   input  wire logic signed [20:0] req_table_data,
   output logic                    rsp_strobe,
   output logic                    rsp_land,
   output logic [1:0]              rsp_status,
   output logic [1:0]              rsp_decided_level,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_data
);

   logic                          accept;
   logic                          push;
   logic                          pop;
   hlsml_pkg::item_type           push_item;
   hlsml_pkg::item_type           head;
   hlsml_pkg::queue_status_type   q_status;
   logic [hlsml_pkg::INFLIGHT_W-1:0]  inflight;
   logic [hlsml_pkg::OCCUPANCY_W-1:0] occupancy;

   // items in the front pipeline already hold a queue slot
   assign occupancy = hlsml_pkg::OCCUPANCY_W'(inflight) +
                      hlsml_pkg::OCCUPANCY_W'(q_status.count);
   assign busy      = occupancy >= hlsml_pkg::OCCUPANCY_W'(hlsml_pkg::QUEUE_DEPTH);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   hlsml_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .latitude      (req_latitude),
      .longitude     (req_longitude),
      .table_address (req_table_address),
      .table_data    (req_table_data),
      .push          (push),
      .item          (push_item),
      .inflight      (inflight)
   );

   hlsml_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   hlsml_back #(
      .TENTH_BLOCK_COUNT  (TENTH_BLOCK_COUNT),
      .BITMAP_BLOCK_COUNT (BITMAP_BLOCK_COUNT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (head),
      .q_status          (q_status),
      .q_pop             (pop),
      .cfg_write         (csr_valid && csr_ready),
      .cfg_data          (csr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_land          (rsp_land),
      .rsp_status        (rsp_status),
      .rsp_decided_level (rsp_decided_level)
   );

endmodule

`default_nettype wire
